// ===== rtl/matrix3_inverse_top_defines.svh =====
// assertion macros for the matrix inverse block
`ifndef MATRIX3_INVERSE_TOP_DEFINES_SVH
`define MATRIX3_INVERSE_TOP_DEFINES_SVH

// same-cycle implication
`define M3I_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("m3i assertion failed");

// next-cycle implication
`define M3I_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("m3i assertion failed");

`endif

// ===== rtl/m3i_pkg.sv =====
`default_nettype none
package m3i_pkg;

  localparam int ELEM_W      = 32;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int COF_W       = PROD_W + 1;
  localparam int PP_W        = ELEM_W + ELEM_W + 1;
  localparam int DET_W       = 3 * ELEM_W + 3;
  localparam int DMAG_W      = 3 * ELEM_W + 1;
  localparam int FRAC_BITS_D = 16;
  localparam int LANE_STAGES = ELEM_W + 3;

  localparam logic [ELEM_W-1:0] POS_LIM = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] NEG_LIM = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DET_W-1:0]  det_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } m3i_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/matrix3_inverse_top.sv =====
// 3x3 fixed-point matrix inverse, adjugate method
// input channel: in_valid / in_stall with the nine elements in_r0c0 .. in_r2c2,
//   signed Q(32-FRAC_BITS).FRAC_BITS
// output channel: out_valid / out_stall with inv_r0c0 .. inv_r2c2, singular
//   and overflow, one result item per input item, in order
// pipeline: 5 stages for products, cofactors and determinant, then 35 stages
//   per element for the one-bit-a-stage restoring divider and saturation
// throughput: one item per cycle while no stall holds the pipeline;
//   all nine divider lanes run in parallel
// a singular matrix gives zero elements, singular high and overflow low
// a saturated element sets overflow
// stall: while a result waits with out_stall high the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated
// reset: synchronous rst empties the pipeline, no result is pending after it
`default_nettype none
module matrix3_inverse_top import m3i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_D
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  elem_t in_r0c0,
  input  elem_t in_r0c1,
  input  elem_t in_r0c2,
  input  elem_t in_r1c0,
  input  elem_t in_r1c1,
  input  elem_t in_r1c2,
  input  elem_t in_r2c0,
  input  elem_t in_r2c1,
  input  elem_t in_r2c2,
  output logic  out_valid,
  input  logic  out_stall,
  output elem_t inv_r0c0,
  output elem_t inv_r0c1,
  output elem_t inv_r0c2,
  output elem_t inv_r1c0,
  output elem_t inv_r1c1,
  output elem_t inv_r1c2,
  output elem_t inv_r2c0,
  output elem_t inv_r2c1,
  output elem_t inv_r2c2,
  output logic  singular,
  output logic  overflow
);

  `include "matrix3_inverse_top_defines.svh"

  logic              en;
  elem_t             m [9];
  cof_t              cof [9];
  logic [DMAG_W-1:0] dmag;
  logic              dneg;
  m3i_ctrl_t         fctrl;
  m3i_ctrl_t         chain [LANE_STAGES];
  elem_t             q [9];
  logic [8:0]        ovf;
  logic              sing;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign m[0] = in_r0c0;
  assign m[1] = in_r0c1;
  assign m[2] = in_r0c2;
  assign m[3] = in_r1c0;
  assign m[4] = in_r1c1;
  assign m[5] = in_r1c2;
  assign m[6] = in_r2c0;
  assign m[7] = in_r2c1;
  assign m[8] = in_r2c2;

  m3i_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .m        (m),
    .cof      (cof),
    .dmag     (dmag),
    .dneg     (dneg),
    .ctrl     (fctrl)
  );

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .cof   (cof[i]),
      .dmag  (dmag),
      .dneg  (dneg),
      .q_out (q[i]),
      .ovf   (ovf[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANE_STAGES; k++) begin
        chain[k] <= '0;
      end
    end else if (en) begin
      chain[0] <= fctrl;
      for (int k = 1; k < LANE_STAGES; k++) begin
        chain[k] <= chain[k-1];
      end
    end
  end

  assign out_valid = chain[LANE_STAGES-1].valid;
  assign sing      = chain[LANE_STAGES-1].singular;
  assign singular  = sing;
  assign overflow  = !sing && (|ovf);

  assign inv_r0c0 = sing ? '0 : q[0];
  assign inv_r0c1 = sing ? '0 : q[1];
  assign inv_r0c2 = sing ? '0 : q[2];
  assign inv_r1c0 = sing ? '0 : q[3];
  assign inv_r1c1 = sing ? '0 : q[4];
  assign inv_r1c2 = sing ? '0 : q[5];
  assign inv_r2c0 = sing ? '0 : q[6];
  assign inv_r2c1 = sing ? '0 : q[7];
  assign inv_r2c2 = sing ? '0 : q[8];

  `M3I_ASSERT_IMPL(a_sing_zero, out_valid && singular, !overflow && inv_r1c1 == '0)
  `M3I_ASSERT_NEXT(a_drain, out_valid && !out_stall && !chain[LANE_STAGES-2].valid, !out_valid)
  `M3I_ASSERT_IMPL(a_stall_link, out_valid && out_stall, in_stall)

endmodule
`default_nettype wire

// ===== rtl/m3i_front.sv =====
`default_nettype none
module m3i_front import m3i_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  elem_t             m [9],
  output cof_t              cof [9],
  output logic [DMAG_W-1:0] dmag,
  output logic              dneg,
  output m3i_ctrl_t         ctrl
);

  localparam int unsigned PA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int unsigned PB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int unsigned PC [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int unsigned PD [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  prod_t p1 [9];
  prod_t p2 [9];
  elem_t m1 [3];
  cof_t  c2 [9];
  elem_t m2 [3];
  pp_t   pl [3];
  pp_t   ph [3];
  cof_t  c3 [9];
  det_t  det;
  det_t  det_next;
  cof_t  c4 [9];
  logic  v [5];
  logic  dzero;

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        p1[i] <= m[PA[i]] * m[PB[i]];
        p2[i] <= m[PC[i]] * m[PD[i]];
      end
      for (int j = 0; j < 3; j++) begin
        m1[j] <= m[j];
      end
    end
  end

  // cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        c2[i] <= cof_t'(p1[i]) - cof_t'(p2[i]);
      end
      m2 <= m1;
    end
  end

  // split products along row 0
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pl[j] <= m2[j] * $signed({1'b0, c2[3*j][ELEM_W-1:0]});
        ph[j] <= m2[j] * $signed(c2[3*j][COF_W-1:ELEM_W]);
      end
      c3 <= c2;
    end
  end

  always_comb begin
    det_next = '0;
    for (int j = 0; j < 3; j++) begin
      det_next = det_next + (det_t'(ph[j]) <<< ELEM_W) + det_t'(pl[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= det_next;
      c4  <= c3;
    end
  end

  // determinant magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      dneg  <= det[DET_W-1];
      dmag  <= DMAG_W'(det[DET_W-1] ? -det : det);
      dzero <= (det == '0);
      cof   <= c4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 5; k++) begin
        v[k] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  assign ctrl.valid    = v[4];
  assign ctrl.singular = dzero;

endmodule
`default_nettype wire

// ===== rtl/m3i_div_lane.sv =====
`default_nettype none
module m3i_div_lane import m3i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_D
) (
  input  logic              clk,
  input  logic              en,
  input  cof_t              cof,
  input  logic [DMAG_W-1:0] dmag,
  input  logic              dneg,
  output elem_t             q_out,
  output logic              ovf
);

  localparam int NW = COF_W + 2 * FRAC_BITS;
  localparam int W  = (NW > DMAG_W + ELEM_W) ? NW : DMAG_W + ELEM_W;

  cof_t              ca;
  logic [W-1:0]      nmag;
  logic              neg1;
  logic [DMAG_W-1:0] d1;
  logic [W-1:0]      r  [ELEM_W+1];
  logic [ELEM_W-1:0] q  [ELEM_W+1];
  logic [DMAG_W-1:0] d  [ELEM_W+1];
  logic              ng [ELEM_W+1];
  logic              bg [ELEM_W+1];
  logic [ELEM_W-1:0] lim;
  logic              sat;
  logic [ELEM_W-1:0] mag;

  assign ca = cof[COF_W-1] ? -cof : cof;

  always_ff @(posedge clk) begin
    if (en) begin
      nmag <= W'($unsigned(ca)) << (2 * FRAC_BITS);
      neg1 <= cof[COF_W-1] ^ dneg;
      d1   <= dmag;
    end
  end

  // load the first divider stage and flag a quotient too large for the output width
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= nmag;
      q[0]  <= '0;
      d[0]  <= d1;
      ng[0] <= neg1;
      bg[0] <= (nmag >= (W'(d1) << ELEM_W));
    end
  end

  for (genvar k = 0; k < ELEM_W; k++) begin : g_step
    logic [W-1:0] ds;
    logic         ge;
    assign ds = W'(d[k]) << (ELEM_W - 1 - k);
    assign ge = (r[k] >= ds);
    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]  <= ge ? r[k] - ds : r[k];
        q[k+1]  <= {q[k][ELEM_W-2:0], ge};
        d[k+1]  <= d[k];
        ng[k+1] <= ng[k];
        bg[k+1] <= bg[k];
      end
    end
  end

  always_comb begin
    lim = ng[ELEM_W] ? NEG_LIM : POS_LIM;
    sat = bg[ELEM_W] || (q[ELEM_W] > lim);
    mag = sat ? lim : q[ELEM_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out <= ng[ELEM_W] ? -$signed(mag) : $signed(mag);
      ovf   <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_matrix3_inverse_top.sv =====
`default_nettype none
module tb_matrix3_inverse_top import m3i_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    elem_t m [9];
  } matrix_t;

  typedef struct {
    elem_t inv [9];
    logic  sing;
    logic  ovf;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  elem_t a [9];
  logic out_valid;
  logic out_stall = 1'b0;
  elem_t q [9];
  logic singular;
  logic overflow;

  matrix_t  pending_mats [$];
  inverse_t expected_invs [$];
  int errors = 0;
  int results_seen = 0;
  int singular_seen = 0;
  int overflow_seen = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  matrix3_inverse_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_r0c0(a[0]), .in_r0c1(a[1]), .in_r0c2(a[2]),
    .in_r1c0(a[3]), .in_r1c1(a[4]), .in_r1c2(a[5]),
    .in_r2c0(a[6]), .in_r2c1(a[7]), .in_r2c2(a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv_r0c0(q[0]), .inv_r0c1(q[1]), .inv_r0c2(q[2]),
    .inv_r1c0(q[3]), .inv_r1c1(q[4]), .inv_r1c2(q[5]),
    .inv_r2c0(q[6]), .inv_r2c1(q[7]), .inv_r2c2(q[8]),
    .singular(singular), .overflow(overflow)
  );

  function automatic inverse_t invert_matrix(matrix_t x);
    inverse_t r;
    logic signed [65:0] c [9];
    logic signed [129:0] det;
    logic signed [129:0] num;
    logic [129:0] nmag;
    logic [129:0] dmag;
    logic [129:0] qmag;
    logic [129:0] lim;
    logic neg;
    c[0] = 66'(x.m[4]) * 66'(x.m[8]) - 66'(x.m[7]) * 66'(x.m[5]);
    c[1] = 66'(x.m[7]) * 66'(x.m[2]) - 66'(x.m[1]) * 66'(x.m[8]);
    c[2] = 66'(x.m[1]) * 66'(x.m[5]) - 66'(x.m[4]) * 66'(x.m[2]);
    c[3] = 66'(x.m[6]) * 66'(x.m[5]) - 66'(x.m[3]) * 66'(x.m[8]);
    c[4] = 66'(x.m[0]) * 66'(x.m[8]) - 66'(x.m[6]) * 66'(x.m[2]);
    c[5] = 66'(x.m[3]) * 66'(x.m[2]) - 66'(x.m[0]) * 66'(x.m[5]);
    c[6] = 66'(x.m[3]) * 66'(x.m[7]) - 66'(x.m[6]) * 66'(x.m[4]);
    c[7] = 66'(x.m[6]) * 66'(x.m[1]) - 66'(x.m[0]) * 66'(x.m[7]);
    c[8] = 66'(x.m[0]) * 66'(x.m[4]) - 66'(x.m[3]) * 66'(x.m[1]);
    det = 130'(x.m[0]) * 130'(c[0]) + 130'(x.m[1]) * 130'(c[3])
        + 130'(x.m[2]) * 130'(c[6]);
    r.sing = (det == 0);
    r.ovf = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (r.sing) begin
        r.inv[i] = '0;
      end else begin
        num = 130'(c[i]) <<< 32;
        neg = num[129] ^ det[129];
        nmag = num[129] ? -num : num;
        dmag = det[129] ? -det : det;
        qmag = nmag / dmag;
        lim = neg ? 130'h80000000 : 130'h7fffffff;
        if (qmag > lim) begin
          r.ovf = 1'b1;
          qmag = lim;
        end
        r.inv[i] = neg ? -elem_t'(qmag[31:0]) : elem_t'(qmag[31:0]);
      end
    end
    return r;
  endfunction

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      for (int i = 0; i < 9; i++) a[i] <= '0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (pending_mats.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          matrix_t x;
          x = pending_mats.pop_front();
          for (int i = 0; i < 9; i++) a[i] <= x.m[i];
          expected_invs.push_back(invert_matrix(x));
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      inverse_t e;
      results_seen++;
      if (expected_invs.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = expected_invs.pop_front();
        for (int i = 0; i < 9; i++)
          if (q[i] !== e.inv[i]) begin
            $error("inv_r%0dc%0d expected %h actual %h", i / 3, i % 3, e.inv[i], q[i]);
            errors++;
          end
        if (singular !== e.sing) begin
          $error("singular expected %b actual %b", e.sing, singular);
          errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %b actual %b", e.ovf, overflow);
          errors++;
        end
        if (e.sing) singular_seen++;
        if (e.ovf) overflow_seen++;
      end
    end
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 34);
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    wait (pending_mats.size() > 0 && pending_mats.size() < 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom());
      1: return elem_t'($signed($urandom_range(0, 2 * 65536 * 4)) - 4 * 65536);
      2: return elem_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom_range(1) ? elem_t'(32'h7fffffff) : elem_t'(32'h80000000);
    endcase
  endfunction

  task automatic add_diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t x;
    for (int i = 0; i < 9; i++) x.m[i] = '0;
    x.m[0] = d0;
    x.m[4] = d1;
    x.m[8] = d2;
    pending_mats.push_back(x);
  endtask

  initial begin
    matrix_t x;
    int kind;
    int cycles;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: identity, scaled, tiny (saturating), singular, extremes
    add_diag(32'h10000, 32'h10000, 32'h10000);
    add_diag(32'h20000, -32'sh40000, 32'h8000);
    add_diag(32'sd1, 32'sd1, 32'sd1);
    add_diag(-32'sd1, 32'sd1, 32'sd1);
    add_diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_diag(32'h80000000, 32'h80000000, 32'h80000000);
    add_diag(32'h80000000, 32'h7fffffff, 32'h80000000);
    add_diag('0, 32'h10000, 32'h10000);
    for (int i = 0; i < 9; i++) x.m[i] = '0;
    pending_mats.push_back(x);
    for (int i = 0; i < 9; i++) x.m[i] = 32'hffffffff;
    pending_mats.push_back(x);
    for (int i = 0; i < 9; i++) x.m[i] = 32'h7fffffff;
    pending_mats.push_back(x);
    for (int i = 0; i < 9; i++) x.m[i] = elem_t'((i + 1) * 65536);
    pending_mats.push_back(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 2) ? elem_t'(32'h80000000) : elem_t'(32'h7fffffff);
    pending_mats.push_back(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? elem_t'(32'h80000000) : elem_t'(32'sd1);
    pending_mats.push_back(x);
    for (int n = 0; n < 450; n++) begin
      kind = $urandom_range(3);
      for (int i = 0; i < 9; i++) x.m[i] = rand_elem($urandom_range(9) == 0 ? 3 : kind);
      if ($urandom_range(9) == 0) begin
        // copying row 0 into row 1 gives a singular matrix
        for (int i = 0; i < 3; i++) x.m[3 + i] = x.m[i];
      end
      pending_mats.push_back(x);
    end
    wait (pending_mats.size() < 150);
    calm = 1'b1;
    wait (pending_mats.size() < 60);
    calm = 1'b0;
    wait (pending_mats.size() == 0);
    @(posedge clk);
    while (in_valid && in_stall) @(posedge clk);
    @(posedge clk);
    cycles = 0;
    while (expected_invs.size() > 0 && cycles < 200000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (60) @(posedge clk);
    if (expected_invs.size() > 0) begin
      $error("%0d result items never arrived", expected_invs.size());
      errors++;
    end
    $display("checked %0d inverses, %0d singular and %0d with saturation",
             results_seen, singular_seen, overflow_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
